// ===== hdl/aco_pkg.sv =====
package aco_pkg;

    localparam logic [2:0] ACT_PREDICT     = 3'd0;
    localparam logic [2:0] ACT_GYRO        = 3'd1;
    localparam logic [2:0] ACT_ACCEL       = 3'd2;
    localparam logic [2:0] ACT_MAGNET      = 3'd3;
    localparam logic [2:0] ACT_READ        = 3'd4;
    localparam logic [2:0] ACT_INIT_ACCEL  = 3'd5;
    localparam logic [2:0] ACT_INIT_MAGNET = 3'd6;

    localparam logic [2:0] CFG_GAIN_ACCEL  = 3'd0;
    localparam logic [2:0] CFG_GAIN_MAGNET = 3'd1;
    localparam logic [2:0] CFG_GAIN_GYRO   = 3'd2;
    localparam logic [2:0] CFG_GAIN_OFFSET = 3'd3;
    localparam logic [2:0] CFG_GRAVITY     = 3'd4;

    localparam logic [23:0] GAIN_ACCEL_RST  = 24'd52624;
    localparam logic [23:0] GAIN_MAGNET_RST = 24'd52624;
    localparam logic [23:0] GAIN_GYRO_RST   = 24'd2438803;
    localparam logic [23:0] GAIN_OFFSET_RST = 24'd5262;
    localparam logic [30:0] GRAVITY_RST     = 31'd642908;

    localparam int DIV_STEPS  = 63;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_CORDIC,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        PH_W,
        PH_ROTG,
        PH_ROTM,
        PH_LP,
        PH_CROSS,
        PH_OFFS,
        PH_ROLL,
        PH_PDIV,
        PH_SQR,
        PH_PITCH
    } phase_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_24
    } shift_t;

    typedef struct packed {
        logic               zero;
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [35:0] z;
    } cordic_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -70'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick3(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic signed [31:0] c,
                                                 input logic [1:0] i);
        logic signed [31:0] r;
        unique case (i)
            2'd1:    r = b;
            2'd2:    r = c;
            default: r = a;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // fold into the right half plane before vectoring
    function automatic cordic_t cordic_fold(input logic signed [35:0] y,
                                            input logic signed [35:0] x);
        cordic_t c;
        c.zero = (x == 36'sd0) && (y == 36'sd0);
        if (x < 36'sd0)
        begin
            c.z = (y >= 36'sd0) ? 36'sd3373259424 : -36'sd3373259424;
            c.x = -x;
            c.y = -y;
        end
        else
        begin
            c.z = 36'sd0;
            c.x = x;
            c.y = y;
        end
        return c;
    endfunction

endpackage

// ===== hdl/attitude_complementary_observer_core.sv =====
// Complementary attitude observer: one beat on s_t* carries an action and a
// vector; only a read action returns a beat on m_t*. All arithmetic runs
// through one shared 34x34 multiplier, a 63-step restoring divider, a
// 32-step square root and a CORDIC_STEPS-step CORDIC, one beat at a time.
// Accel/magnet updates add per-axis cross-product, divide and offset work
// only when delta_t is nonzero. A finished read result sits in an output
// register so the next beat is taken while it waits.
module attitude_complementary_observer_core #(
    parameter int CORDIC_STEPS  = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, vec_x, vec_y, vec_z, delta_t, zero pad
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // roll, pitch, rate_x, rate_y, rate_z, zero pad
    output logic [135:0] m_tdata,
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);
    import aco_pkg::*;

    localparam int F = FRACTION_BITS;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0] k_reg, k_next;
    logic       t_reg, t_next;
    logic [5:0] it_reg, it_next;

    logic [2:0]  action_reg, action_next;
    logic [23:0] dt_reg, dt_next;
    logic signed [31:0] smp_reg [3];
    logic signed [31:0] smp_next [3];

    logic signed [31:0] grav_reg [3];
    logic signed [31:0] grav_next [3];
    logic signed [31:0] magn_reg [3];
    logic signed [31:0] magn_next [3];
    logic signed [31:0] rate_reg [3];
    logic signed [31:0] rate_next [3];
    logic signed [31:0] offs_reg [3];
    logic signed [31:0] offs_next [3];
    logic signed [31:0] old_reg [3];
    logic signed [31:0] old_next [3];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] res_next [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] w_next [3];

    logic [23:0] gain_accel_reg, gain_magnet_reg, gain_gyro_reg, gain_offset_reg;
    logic [30:0] gravity_reg;

    logic signed [67:0] prod_reg, prod_next;
    logic signed [69:0] acc_reg, acc_next;

    logic [62:0] num_reg, num_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] r_reg, r_next;

    logic [62:0] sq_n_reg, sq_n_next;
    logic [62:0] sq_r_reg, sq_r_next;
    logic [62:0] sq_b_reg, sq_b_next;

    cordic_t cord_reg, cord_next;
    logic [18:0] roll_reg, roll_next;
    logic [17:0] pitch_reg, pitch_next;

    logic        out_valid_reg, out_valid_next;
    logic [18:0] out_roll_reg, out_roll_next;
    logic [17:0] out_pitch_reg, out_pitch_next;
    logic signed [31:0] out_rx_reg, out_rx_next;
    logic signed [31:0] out_ry_reg, out_ry_next;
    logic signed [31:0] out_rz_reg, out_rz_next;

    logic [2:0]  in_action;
    logic signed [31:0] in_vec [3];
    logic [23:0] in_dt;
    logic        in_acc;

    logic signed [31:0] vsel [3];
    logic [1:0]  ka, kb;
    logic signed [33:0] op_a, op_b;
    logic signed [31:0] base;
    shift_t      shift;
    logic        term_neg;
    logic        last_t;
    logic [23:0] gsel;
    logic [24:0] ginv;

    logic signed [69:0] prod_x, term, sum;
    logic signed [31:0] fin_sat, fin_lp;
    logic signed [69:0] cmag;
    logic        k_last, lp_skip, cross_sat;
    logic        div_last, sqrt_last, cordic_last, out_free;

    logic [31:0] rem2;
    logic        div_ge;
    logic [62:0] sq_rb;
    logic signed [35:0] cdx, cdy, catan, zfin, angle;
    logic signed [32:0] gy_mag;
    logic [30:0] pclamp;

    assign in_action = s_tdata[2:0];
    assign in_vec[0] = s_tdata[34:3];
    assign in_vec[1] = s_tdata[66:35];
    assign in_vec[2] = s_tdata[98:67];
    assign in_dt     = s_tdata[122:99];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_rz_reg, out_ry_reg, out_rx_reg, out_pitch_reg, out_roll_reg};

    // operand selection for the shared multiplier
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            vsel[j] = grav_reg[j];
        end
        unique case (phase_reg)
            PH_ROTM:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    vsel[j] = magn_reg[j];
                end
            end
            PH_LP, PH_CROSS:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (action_reg == ACT_GYRO)
                        vsel[j] = rate_reg[j];
                    else if (action_reg == ACT_MAGNET)
                        vsel[j] = magn_reg[j];
                    else
                        vsel[j] = grav_reg[j];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ka = inc3(k_reg);
    assign kb = inc3(ka);

    always_comb
    begin
        gsel = gain_accel_reg;
        if (action_reg == ACT_GYRO)
            gsel = gain_gyro_reg;
        else if (action_reg == ACT_MAGNET)
            gsel = gain_magnet_reg;
    end
    assign ginv = 25'h1000000 - {1'b0, gsel};

    always_comb
    begin
        op_a     = 34'sd0;
        op_b     = 34'sd0;
        base     = 32'sd0;
        shift    = SH_NONE;
        term_neg = 1'b0;
        last_t   = t_reg;
        unique case (phase_reg)
            PH_W:
            begin
                op_a   = $signed({10'd0, dt_reg});
                op_b   = 34'(33'(pick3(rate_reg[0], rate_reg[1], rate_reg[2], k_reg))
                       - 33'(pick3(offs_reg[0], offs_reg[1], offs_reg[2], k_reg)));
                shift  = SH_24;
                last_t = 1'b1;
            end
            PH_ROTG, PH_ROTM:
            begin
                base  = pick3(vsel[0], vsel[1], vsel[2], k_reg);
                shift = SH_FRAC;
                if (!t_reg)
                begin
                    op_a = 34'(pick3(w_reg[0], w_reg[1], w_reg[2], kb));
                    op_b = 34'(pick3(vsel[0], vsel[1], vsel[2], ka));
                end
                else
                begin
                    op_a     = 34'(pick3(w_reg[0], w_reg[1], w_reg[2], ka));
                    op_b     = 34'(pick3(vsel[0], vsel[1], vsel[2], kb));
                    term_neg = 1'b1;
                end
            end
            PH_LP:
            begin
                if (!t_reg)
                begin
                    op_a = $signed({9'd0, ginv});
                    op_b = 34'(pick3(vsel[0], vsel[1], vsel[2], k_reg));
                end
                else
                begin
                    op_a = $signed({10'd0, gsel});
                    op_b = 34'(pick3(smp_reg[0], smp_reg[1], smp_reg[2], k_reg));
                end
            end
            PH_CROSS:
            begin
                shift = SH_FRAC;
                if (!t_reg)
                begin
                    op_a = 34'(pick3(old_reg[0], old_reg[1], old_reg[2], ka));
                    op_b = 34'(pick3(vsel[0], vsel[1], vsel[2], kb));
                end
                else
                begin
                    op_a     = 34'(pick3(old_reg[0], old_reg[1], old_reg[2], kb));
                    op_b     = 34'(pick3(vsel[0], vsel[1], vsel[2], ka));
                    term_neg = 1'b1;
                end
            end
            PH_OFFS:
            begin
                op_a   = $signed({10'd0, gain_offset_reg});
                op_b   = 34'(q_reg);
                base   = pick3(offs_reg[0], offs_reg[1], offs_reg[2], k_reg);
                shift  = SH_24;
                last_t = 1'b1;
            end
            PH_SQR:
            begin
                op_a   = 34'(r_reg);
                op_b   = 34'(r_reg);
                last_t = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // accumulate with per-term rounding
    assign prod_x = 70'(prod_reg);
    always_comb
    begin
        unique case (shift)
            SH_FRAC: term = (prod_x + (70'sd1 <<< (F - 1))) >>> F;
            SH_24:   term = (prod_x + 70'sd8388608) >>> 24;
            default: term = prod_x;
        endcase
    end
    assign sum     = acc_reg + (term_neg ? -term : term);
    assign fin_sat = sat32(sum);
    assign fin_lp  = 32'((sum + 70'sd8388608) >>> 24);
    assign cmag    = (sum < 70'sd0) ? -sum : sum;

    assign k_last    = (k_reg == 2'd2);
    assign lp_skip   = (action_reg == ACT_GYRO) || (dt_reg == 24'd0);
    assign cross_sat = |cmag[69:39];

    assign div_last    = (it_reg == 6'(DIV_STEPS - 1));
    assign sqrt_last   = (it_reg == 6'(SQRT_STEPS - 1));
    assign cordic_last = (it_reg == 6'(CORDIC_STEPS - 1));
    assign out_free    = !out_valid_reg || m_tready;

    assign rem2   = {rem_reg, num_reg[62]};
    assign div_ge = (rem2 >= {1'b0, den_reg});
    assign sq_rb  = sq_r_reg + sq_b_reg;

    assign cdx   = cord_reg.y >>> it_reg;
    assign cdy   = cord_reg.x >>> it_reg;
    assign catan = $signed({6'd0, atan_q30(it_reg[4:0])});
    assign zfin  = (cord_reg.y > 36'sd0) ? cord_reg.z + catan : cord_reg.z - catan;
    assign angle = (zfin + (36'sd1 <<< (29 - F))) >>> (30 - F);

    assign gy_mag = (grav_reg[1] < 32'sd0) ? -33'(grav_reg[1]) : 33'(grav_reg[1]);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_action == ACT_PREDICT || in_action == ACT_GYRO
                        || in_action == ACT_ACCEL || in_action == ACT_MAGNET)
                        state_next = ST_MUL;
                    else if (in_action == ACT_READ)
                        state_next = ST_CORDIC;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!last_t)
                    state_next = ST_MUL;
                else
                begin
                    unique case (phase_reg)
                        PH_ROTM, PH_OFFS: state_next = k_last ? ST_IDLE : ST_MUL;
                        PH_LP:    state_next = (k_last && lp_skip) ? ST_IDLE : ST_MUL;
                        PH_CROSS: state_next = cross_sat ? ST_MUL : ST_DIV;
                        PH_SQR:   state_next = ST_SQRT;
                        PH_W, PH_ROTG: state_next = ST_MUL;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_MUL;
            end
            ST_SQRT:
            begin
                if (sqrt_last)
                    state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (cordic_last)
                    state_next = (phase_reg == PH_ROLL) ? ST_DIV : ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        phase_next  = phase_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        it_next     = it_reg;
        action_next = action_reg;
        dt_next     = dt_reg;
        for (int j = 0; j < 3; j++)
        begin
            smp_next[j]  = smp_reg[j];
            grav_next[j] = grav_reg[j];
            magn_next[j] = magn_reg[j];
            rate_next[j] = rate_reg[j];
            offs_next[j] = offs_reg[j];
            old_next[j]  = old_reg[j];
            res_next[j]  = res_reg[j];
            w_next[j]    = w_reg[j];
        end
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        sq_n_next      = sq_n_reg;
        sq_r_next      = sq_r_reg;
        sq_b_next      = sq_b_reg;
        cord_next      = cord_reg;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_roll_next  = out_roll_reg;
        out_pitch_next = out_pitch_reg;
        out_rx_next    = out_rx_reg;
        out_ry_next    = out_ry_reg;
        out_rz_next    = out_rz_reg;
        pclamp         = 31'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    action_next = in_action;
                    dt_next     = in_dt;
                    k_next      = 2'd0;
                    t_next      = 1'b0;
                    it_next     = 6'd0;
                    for (int j = 0; j < 3; j++)
                    begin
                        smp_next[j] = in_vec[j];
                    end
                    priority case (in_action)
                        ACT_PREDICT: phase_next = PH_W;
                        ACT_GYRO, ACT_ACCEL, ACT_MAGNET: phase_next = PH_LP;
                        ACT_READ:
                        begin
                            phase_next = PH_ROLL;
                            cord_next  = cordic_fold(-36'(grav_reg[0]), 36'(grav_reg[2]));
                        end
                        ACT_INIT_ACCEL, ACT_INIT_MAGNET:
                        begin
                            for (int j = 0; j < 3; j++)
                            begin
                                if (in_action == ACT_INIT_ACCEL)
                                    grav_next[j] = in_vec[j];
                                else
                                    magn_next[j] = in_vec[j];
                                rate_next[j] = 32'sd0;
                                offs_next[j] = 32'sd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next = 68'(op_a) * 68'(op_b);
                if (!t_reg)
                    acc_next = 70'(base);
            end
            ST_ACC:
            begin
                acc_next = sum;
                if (!last_t)
                    t_next = 1'b1;
                else
                begin
                    t_next = 1'b0;
                    k_next = k_last ? 2'd0 : ka;
                    unique case (phase_reg)
                        PH_W:
                        begin
                            for (int j = 0; j < 3; j++)
                            begin
                                if (k_reg == 2'(j))
                                    w_next[j] = fin_sat;
                            end
                            if (k_last)
                                phase_next = PH_ROTG;
                        end
                        PH_ROTG, PH_ROTM:
                        begin
                            for (int j = 0; j < 3; j++)
                            begin
                                if (k_reg == 2'(j))
                                    res_next[j] = fin_sat;
                            end
                            if (k_last)
                            begin
                                if (phase_reg == PH_ROTG)
                                begin
                                    grav_next[0] = res_reg[0];
                                    grav_next[1] = res_reg[1];
                                    grav_next[2] = fin_sat;
                                    phase_next   = PH_ROTM;
                                end
                                else
                                begin
                                    magn_next[0] = res_reg[0];
                                    magn_next[1] = res_reg[1];
                                    magn_next[2] = fin_sat;
                                end
                            end
                        end
                        PH_LP:
                        begin
                            for (int j = 0; j < 3; j++)
                            begin
                                if (k_reg == 2'(j))
                                    res_next[j] = fin_lp;
                            end
                            if (k_last)
                            begin
                                phase_next = PH_CROSS;
                                for (int j = 0; j < 3; j++)
                                begin
                                    old_next[j] = vsel[j];
                                end
                                if (action_reg == ACT_GYRO)
                                begin
                                    rate_next[0] = res_reg[0];
                                    rate_next[1] = res_reg[1];
                                    rate_next[2] = fin_lp;
                                end
                                else if (action_reg == ACT_MAGNET)
                                begin
                                    magn_next[0] = res_reg[0];
                                    magn_next[1] = res_reg[1];
                                    magn_next[2] = fin_lp;
                                end
                                else
                                begin
                                    grav_next[0] = res_reg[0];
                                    grav_next[1] = res_reg[1];
                                    grav_next[2] = fin_lp;
                                end
                            end
                        end
                        PH_CROSS:
                        begin
                            k_next   = k_reg;
                            neg_next = (sum < 70'sd0);
                            if (cross_sat)
                            begin
                                q_next     = (sum < 70'sd0) ? 32'sh80000000 : 32'sh7FFFFFFF;
                                phase_next = PH_OFFS;
                            end
                            else
                            begin
                                num_next = {cmag[38:0], 24'd0};
                                den_next = {7'd0, dt_reg};
                                rem_next = 31'd0;
                                it_next  = 6'd0;
                            end
                        end
                        PH_OFFS:
                        begin
                            for (int j = 0; j < 3; j++)
                            begin
                                if (k_reg == 2'(j))
                                    offs_next[j] = fin_sat;
                            end
                            phase_next = PH_CROSS;
                        end
                        PH_SQR:
                        begin
                            sq_n_next = 63'h1000000000000000 - {2'd0, sum[60:0]};
                            sq_r_next = 63'd0;
                            sq_b_next = 63'h4000000000000000;
                            it_next   = 6'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? 31'(rem2 - {1'b0, den_reg}) : rem2[30:0];
                num_next = {num_reg[61:0], div_ge};
                it_next  = it_reg + 6'd1;
                if (div_last)
                begin
                    t_next = 1'b0;
                    if (phase_reg == PH_CROSS)
                    begin
                        phase_next = PH_OFFS;
                        if (|num_next[62:31])
                            q_next = neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
                        else
                            q_next = neg_reg ? -$signed({1'b0, num_next[30:0]})
                                             : $signed({1'b0, num_next[30:0]});
                    end
                    else
                    begin
                        phase_next = PH_SQR;
                        pclamp = (num_next > 63'h40000000) ? 31'h40000000 : num_next[30:0];
                        r_next = neg_reg ? -$signed({1'b0, pclamp})
                                         : $signed({1'b0, pclamp});
                    end
                end
            end
            ST_SQRT:
            begin
                if (sq_n_reg >= sq_rb)
                begin
                    sq_n_next = sq_n_reg - sq_rb;
                    sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                    sq_r_next = sq_r_reg >> 1;
                sq_b_next = sq_b_reg >> 2;
                it_next   = it_reg + 6'd1;
                if (sqrt_last)
                begin
                    phase_next = PH_PITCH;
                    it_next    = 6'd0;
                    cord_next  = cordic_fold(36'(r_reg), $signed(sq_r_next[35:0]));
                end
            end
            ST_CORDIC:
            begin
                if (cord_reg.y > 36'sd0)
                begin
                    cord_next.x = cord_reg.x + cdx;
                    cord_next.y = cord_reg.y - cdy;
                end
                else
                begin
                    cord_next.x = cord_reg.x - cdx;
                    cord_next.y = cord_reg.y + cdy;
                end
                cord_next.z = zfin;
                it_next     = it_reg + 6'd1;
                if (cordic_last)
                begin
                    it_next = 6'd0;
                    if (phase_reg == PH_ROLL)
                    begin
                        roll_next  = cord_reg.zero ? 19'd0 : angle[18:0];
                        phase_next = PH_PDIV;
                        neg_next   = (grav_reg[1] < 32'sd0);
                        num_next   = {1'b0, gy_mag[31:0], 30'd0};
                        den_next   = (gravity_reg == 31'd0) ? 31'd1 : gravity_reg;
                        rem_next   = 31'd0;
                    end
                    else
                        pitch_next = cord_reg.zero ? 18'd0 : angle[17:0];
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_roll_next  = roll_reg;
                    out_pitch_next = pitch_reg;
                    out_rx_next    = sat32(70'(rate_reg[1]) - 70'(offs_reg[1]));
                    out_ry_next    = sat32(70'(rate_reg[0]) - 70'(offs_reg[0]));
                    out_rz_next    = sat32(70'(offs_reg[2]) - 70'(rate_reg[2]));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_W;
            k_reg           <= 2'd0;
            t_reg           <= 1'b0;
            it_reg          <= 6'd0;
            action_reg      <= ACT_PREDICT;
            out_valid_reg   <= 1'b0;
            gain_accel_reg  <= GAIN_ACCEL_RST;
            gain_magnet_reg <= GAIN_MAGNET_RST;
            gain_gyro_reg   <= GAIN_GYRO_RST;
            gain_offset_reg <= GAIN_OFFSET_RST;
            gravity_reg     <= GRAVITY_RST;
            for (int j = 0; j < 3; j++)
            begin
                grav_reg[j] <= 32'sd0;
                magn_reg[j] <= 32'sd0;
                rate_reg[j] <= 32'sd0;
                offs_reg[j] <= 32'sd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            it_reg        <= it_next;
            action_reg    <= action_next;
            out_valid_reg <= out_valid_next;
            for (int j = 0; j < 3; j++)
            begin
                grav_reg[j] <= grav_next[j];
                magn_reg[j] <= magn_next[j];
                rate_reg[j] <= rate_next[j];
                offs_reg[j] <= offs_next[j];
            end
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_GAIN_ACCEL:  gain_accel_reg  <= cfg_wdata[23:0];
                    CFG_GAIN_MAGNET: gain_magnet_reg <= cfg_wdata[23:0];
                    CFG_GAIN_GYRO:   gain_gyro_reg   <= cfg_wdata[23:0];
                    CFG_GAIN_OFFSET: gain_offset_reg <= cfg_wdata[23:0];
                    CFG_GRAVITY:     gravity_reg     <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg        <= dt_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        neg_reg       <= neg_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        sq_n_reg      <= sq_n_next;
        sq_r_reg      <= sq_r_next;
        sq_b_reg      <= sq_b_next;
        cord_reg      <= cord_next;
        roll_reg      <= roll_next;
        pitch_reg     <= pitch_next;
        out_roll_reg  <= out_roll_next;
        out_pitch_reg <= out_pitch_next;
        out_rx_reg    <= out_rx_next;
        out_ry_reg    <= out_ry_next;
        out_rz_reg    <= out_rz_next;
        for (int j = 0; j < 3; j++)
        begin
            smp_reg[j] <= smp_next[j];
            old_reg[j] <= old_next[j];
            res_reg[j] <= res_next[j];
            w_reg[j]   <= w_next[j];
        end
    end

    // square root bit walks down one position pair per step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> $onehot(sq_b_reg))
        else $error("sqrt bit not one-hot");

    // cordic x stays in the right half plane
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORDIC) |-> (cord_reg.x >= 36'sd0))
        else $error("cordic x negative");

    // a new result only comes out of the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result without read");

    // divider only runs for the cross or pitch quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (phase_reg == PH_CROSS || phase_reg == PH_PDIV))
        else $error("divider in wrong phase");

endmodule
